// ----- design/assert_macros.svh -----
// Assertion macros shared by the correlation table RTL.
// Depends on nothing; taken in by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// Next-cycle implication outside reset.
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

// ----- design/pmct_pkg.sv -----
// Package for the pair mark correlation table: codes, types, widths.
// Used by the controller, datapath and top level.
`default_nettype none
package pmct_pkg;
  localparam logic [2:0] DET_INTENT = 3'd0;
  localparam logic [2:0] DET_NONIMG = 3'd1;
  localparam logic [2:0] DET_HIJACK = 3'd2;
  localparam logic [2:0] DET_CHAIN  = 3'd3;
  localparam logic [2:0] DET_MMAP   = 3'd4;
  localparam logic [2:0] DET_STRONG = 3'd5;

  localparam logic [2:0] CFG_WINDOW   = 3'd0;
  localparam logic [2:0] CFG_COOLDOWN = 3'd1;
  localparam logic [2:0] CFG_STALE    = 3'd2;
  localparam logic [2:0] CFG_TCTX     = 3'd3;
  localparam logic [2:0] CFG_MEM      = 3'd4;
  localparam logic [2:0] CFG_DUP      = 3'd5;

  // Request fields take 227 bits, padded to whole bytes on the bus.
  localparam int IN_BITS = 227;
  localparam int IN_W    = 232;
  localparam int OUT_W   = 168;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;      // latch request
    logic clr_step;  // clear one entry at clr address
    logic scan_rd;   // issue read at scan address
    logic scan_eval; // evaluate returned entry
    logic upd;       // write back merged entry
    logic emit;      // present next result
  } cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic zero_tgt;
    logic no_marks;
    logic found;     // scan stopped early
    logic [5:0] pend; // immediate + strong pending results
  } sts_t;
endpackage
`default_nettype wire

// ----- design/pmct_ctrl.sv -----
// Controller state machine: clear pass, scan sequencing, update, emit.
// Depends on pmct_pkg.
`default_nettype none
module pmct_ctrl #(
  parameter int AW = 8,
  parameter int N  = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_fire,
  input  wire pmct_pkg::sts_t sts,
  output pmct_pkg::cmd_t cmd,
  output logic [AW-1:0] addr,
  output logic idle,
  output logic out_valid
);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_CHK = 3'd2, S_RD = 3'd3,
                         S_EV = 3'd4, S_UPD = 3'd5, S_EMIT = 3'd6;
  logic [2:0] st_r, st_nxt;
  logic [AW:0] cnt_r, cnt_nxt;

  assign addr = cnt_r[AW-1:0];
  assign idle = (st_r == S_IDLE);

  // Offer a result only in the emit phase with work pending
  assign out_valid = (st_r == S_EMIT) && (sts.pend != '0);

  // Next-state and command decode
  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    unique case (st_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(N - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) st_nxt = S_CHK;
      end
      S_CHK: begin
        cnt_nxt = '0;
        if (sts.zero_tgt) st_nxt = S_IDLE;
        else if (sts.no_marks) st_nxt = (sts.pend != '0) ? S_EMIT : S_IDLE;
        else st_nxt = S_RD;
      end
      S_RD: begin
        cmd.scan_rd = 1'b1;
        st_nxt = S_EV;
      end
      S_EV: begin
        cmd.scan_eval = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (sts.found || cnt_r == (AW+1)'(N - 1)) st_nxt = S_UPD;
        else st_nxt = S_RD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.pend == '0) st_nxt = S_IDLE;
        else cmd.emit = out_fire;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- design/pmct_dp.sv -----
// Datapath: request latch, detection logic, table memory, scan and merge.
// Depends on pmct_pkg.
`default_nettype none
module pmct_dp #(
  parameter int AW = 8,
  parameter int N  = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire pmct_pkg::cmd_t cmd,
  input  wire logic [AW-1:0] addr,
  input  wire logic [pmct_pkg::IN_BITS-1:0] in_data,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [47:0] cfg_data,
  output pmct_pkg::sts_t sts,
  output logic [pmct_pkg::OUT_W-1:0] res_data,
  output logic res_last
);
  // Configuration registers
  logic [47:0] win_r, cool_r, stale_r;
  logic [31:0] mtc_r, mmem_r, mdup_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 48'd300000000; cool_r <= 48'd30000000; stale_r <= 48'd600000000;
      mtc_r <= 32'd1; mmem_r <= 32'd2; mdup_r <= 32'd4;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pmct_pkg::CFG_WINDOW:   win_r <= cfg_data;
        pmct_pkg::CFG_COOLDOWN: cool_r <= cfg_data;
        pmct_pkg::CFG_STALE:    stale_r <= cfg_data;
        pmct_pkg::CFG_TCTX:     mtc_r <= cfg_data[31:0];
        pmct_pkg::CFG_MEM:      mmem_r <= cfg_data[31:0];
        pmct_pkg::CFG_DUP:      mdup_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Request latch
  logic [31:0] tgt_r, act_r, fl_r, acc_r, age_r;
  logic [62:0] now_r;
  logic outs_r, got_r, exe_r, nimg_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r <= in_data[31:0];
      act_r <= (in_data[63:32] == '0) ? in_data[31:0] : in_data[63:32];
      outs_r <= in_data[64]; got_r <= in_data[65];
      exe_r <= in_data[66]; nimg_r <= in_data[67];
      fl_r <= in_data[99:68]; acc_r <= in_data[131:100];
      age_r <= in_data[163:132]; now_r <= in_data[226:164];
    end
  end

  // Event marks and immediate detections
  logic remote, rnx, tctx, mem, dup;
  logic [5:0] marks, imm;
  assign remote = act_r != tgt_r;
  assign rnx = remote & got_r & exe_r & nimg_r;
  assign tctx = (fl_r & mtc_r) != '0;
  assign mem  = (fl_r & mmem_r) != '0;
  assign dup  = (fl_r & mdup_r) != '0;
  assign marks = {dup, tctx, mem, rnx, outs_r, remote};
  assign imm = {1'b0, rnx & mem & tctx, rnx & mem & (tctx | dup),
                rnx & tctx & mem, rnx & mem, remote & mem & (tctx | dup)};

  // Table memory, one entry wide word
  localparam int EW = 1 + 32*5 + 6 + 63*3;
  logic [EW-1:0] mem_q [N];
  logic [EW-1:0] rd_r, wr_w;
  logic [AW-1:0] wa;
  logic we;
  always_ff @(posedge clk) begin
    if (we) mem_q[wa] <= wr_w;
    rd_r <= mem_q[addr];
  end

  // Scan state
  logic found_r, cand_v_r, cand_match_r;
  logic [AW-1:0] cand_r, ev_a_r;
  logic [62:0] oldest_r;
  logic [EW-1:0] cand_e_r;
  logic e_v; logic [31:0] e_act, e_tgt; logic [62:0] e_ls;
  logic [62:0] dls;
  logic take, match, older;
  assign e_v = rd_r[EW-1];
  assign e_act = rd_r[EW-2 -: 32];
  assign e_tgt = rd_r[EW-34 -: 32];
  assign e_ls = rd_r[125:63];
  assign dls = (now_r > e_ls) ? now_r - e_ls : '0;
  assign match = e_v && e_act == act_r && e_tgt == tgt_r;
  assign take = !e_v || (!match && {15'd0, stale_r} < dls);
  assign older = e_ls < oldest_r;

  always_ff @(posedge clk) begin
    if (cmd.load || !rst_n) begin
      found_r <= 1'b0; cand_v_r <= 1'b0; cand_match_r <= 1'b0;
      oldest_r <= '1;
    end else if (cmd.scan_eval) begin
      if (match) begin
        found_r <= 1'b1; cand_v_r <= 1'b1; cand_match_r <= 1'b1;
        cand_r <= ev_a_r; cand_e_r <= rd_r;
      end else if (take) begin
        found_r <= 1'b1; cand_v_r <= 1'b1; cand_r <= ev_a_r;
      end else if (older) begin
        oldest_r <= e_ls; cand_v_r <= 1'b1; cand_r <= ev_a_r;
      end
    end
    if (cmd.scan_rd) ev_a_r <= addr;
  end

  // Merge into chosen entry
  logic [5:0] b_mk, m_mk; logic [31:0] b_fl, b_ac, b_ag, m_fl, m_ac, m_ag;
  logic [62:0] b_fs, b_lst, m_fs, dfs, dlst;
  logic expired, strong_chain, fire;
  always_comb begin
    if (cand_match_r) begin
      b_mk = cand_e_r[EW-66 -: 6]; b_fl = cand_e_r[EW-72 -: 32];
      b_ac = cand_e_r[EW-104 -: 32]; b_ag = cand_e_r[EW-136 -: 32];
      b_fs = cand_e_r[188:126]; b_lst = cand_e_r[62:0];
    end else begin
      b_mk = '0; b_fl = '0; b_ac = '0; b_ag = '0; b_fs = now_r; b_lst = '0;
    end
    m_mk = b_mk | marks; m_fl = b_fl | fl_r; m_ac = b_ac | acc_r;
    m_ag = (age_r != '0) ? age_r : b_ag;
    m_fs = (b_fs == '0) ? now_r : b_fs;
  end
  assign dfs = (now_r > m_fs) ? now_r - m_fs : '0;
  assign dlst = (now_r > b_lst) ? now_r - b_lst : '0;
  assign expired = dfs > {15'd0, win_r};
  assign strong_chain = m_mk[0] & m_mk[2] & m_mk[3] & (m_mk[4] | m_mk[5]);
  assign fire = !expired && strong_chain && (b_lst == '0 || dlst >= {15'd0, cool_r});

  // Memory write: clear pass or update
  always_comb begin
    we = cmd.clr_step || (cmd.upd && cand_v_r);
    wa = cmd.clr_step ? addr : cand_r;
    if (cmd.clr_step) wr_w = '0;
    else if (expired)
      wr_w = {1'b1, act_r, tgt_r, 6'd0, 96'd0, now_r, now_r, b_lst};
    else
      wr_w = {1'b1, act_r, tgt_r, m_mk, m_fl, m_ac, m_ag, m_fs, now_r,
              fire ? now_r : b_lst};
  end

  // Result queue: pending bits in code order plus strong snapshot
  logic [5:0] pend_r;
  logic [31:0] sf_r, sa_r, sg_r;
  logic [5:0] low1;
  logic [2:0] code;
  assign low1 = pend_r & (~pend_r + 6'd1);
  always_comb begin
    code = pmct_pkg::DET_INTENT;
    for (int i = 5; i >= 0; i--) if (low1[i]) code = 3'(i);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else if (cmd.load) pend_r <= '0;
    else if (cmd.scan_rd && pend_r == '0 && !cand_v_r && addr == '0) pend_r <= imm;
    else if (cmd.upd) begin
      pend_r <= imm | {cand_v_r & fire, 5'd0};
      sf_r <= m_fl; sa_r <= m_ac; sg_r <= m_ag;
    end else if (cmd.emit) pend_r <= pend_r & ~low1;
  end

  // The no-marks path loads immediates directly; immediates imply at least remote
  logic [5:0] pend_v;
  logic nm_load_r;
  always_ff @(posedge clk) begin
    if (!rst_n) nm_load_r <= 1'b0;
    else nm_load_r <= cmd.load;
  end
  assign pend_v = (nm_load_r && marks == '0) ? imm : pend_r;

  logic [2:0] sev;
  always_comb begin
    unique case (code) inside
      pmct_pkg::DET_INTENT: sev = 3'd5;
      pmct_pkg::DET_CHAIN, pmct_pkg::DET_STRONG: sev = 3'd7;
      default: sev = 3'd6;
    endcase
  end
  logic strong_o;
  assign strong_o = code == pmct_pkg::DET_STRONG;
  assign res_data = {2'd0,
                     strong_o ? sg_r : age_r, strong_o ? sa_r : acc_r,
                     strong_o ? sf_r : fl_r, tgt_r, act_r, sev, code};
  assign res_last = (pend_r & ~low1) == '0;

  assign sts.zero_tgt = tgt_r == '0;
  assign sts.no_marks = marks == '0;
  assign sts.found = found_r || (cmd.scan_eval && (match || take));
  assign sts.pend = pend_v;
endmodule
`default_nettype wire

// ----- design/pair_mark_correlation_table_core.sv -----
// Top level of the pair mark correlation table.
// Depends on pmct_pkg, pmct_ctrl, pmct_dp and assert_macros.svh.
//   channel | dir | contents
//   in_     | in  | one thread observation event
//   out_    | out | detections, tlast on the last one of an event
//   cfg_    | in  | register writes, index 0..5
// After reset a clearing pass over every table entry runs before the first
// request is taken. The next request is taken only when the last one is
// done: a zero target or no marks skips the scan, else the table is read
// slot by slot through its single read port up to a usable slot or its
// end and then updated, and the event's results are sent.
// Reset is synchronous, active low. out_tready low holds the pending result.
`default_nettype none
`include "assert_macros.svh"
module pair_mark_correlation_table_core #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_tvalid,
  output logic in_tready,
  // target_id, actor_id, outside_image, got_start, start_executable,
  // start_non_image, intent_flags, intent_access, intent_age, now_ticks
  input  wire  logic [pmct_pkg::IN_W-1:0] in_tdata,
  output logic out_tvalid,
  input  wire  logic out_tready,
  // detection_code, severity, out_actor, out_target, out_flags, out_access,
  // out_age
  output logic [pmct_pkg::OUT_W-1:0] out_tdata,
  output logic out_tlast,
  input  wire  logic cfg_we,
  input  wire  logic [2:0] cfg_index,
  input  wire  logic [47:0] cfg_data
);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  pmct_pkg::cmd_t cmd;
  pmct_pkg::sts_t sts;
  logic [AW-1:0] addr;
  logic idle, res_last;
  logic [pmct_pkg::OUT_W-1:0] res;

  pmct_ctrl #(.AW(AW), .N(TABLE_ENTRIES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid & in_tready),
    .out_fire(out_tvalid & out_tready), .sts(sts), .cmd(cmd), .addr(addr),
    .idle(idle), .out_valid(out_tvalid));

  pmct_dp #(.AW(AW), .N(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .addr(addr),
    .in_data(in_tdata[pmct_pkg::IN_BITS-1:0]),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data), .sts(sts),
    .res_data(res), .res_last(res_last));

  // Take requests only when idle; drive results from the datapath
  assign in_tready = idle;
  assign out_tdata = res;
  assign out_tlast = res_last;

  `CHK_IMPLY(a_ready_idle, clk, rst_n, in_tready, !out_tvalid)
  `CHK_NEXT(a_take_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule
`default_nettype wire

// ----- verif/pair_mark_correlation_table_core_test.sv -----
// Self-checking testbench for pair_mark_correlation_table_core.
// Needs pmct_pkg and the core RTL; predicts each event's detections and
// compares them field by field on the result stream.
`default_nettype none
module pair_mark_correlation_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 256;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 80;
  localparam logic [62:0] TMAX = 63'h7FFF_FFFF_FFFF_FFFF;

  // Mark bits kept per pair.
  localparam logic [5:0] MK_REMOTE  = 6'h01;
  localparam logic [5:0] MK_OUTSIDE = 6'h02;
  localparam logic [5:0] MK_NONIMG  = 6'h04;
  localparam logic [5:0] MK_MEM     = 6'h08;
  localparam logic [5:0] MK_TCTX    = 6'h10;
  localparam logic [5:0] MK_DUP     = 6'h20;

  typedef struct {
    logic [31:0] tgt, act;
    logic outside, got, exe, nonimg;
    logic [31:0] flags, access, age;
    logic [62:0] now;
  } event_t;

  typedef struct {
    logic [2:0] code, sev;
    logic [31:0] act, tgt, flags, access, age;
    logic last;
  } detect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [pmct_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [pmct_pkg::OUT_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = pmct_pkg::CFG_WINDOW;
  logic [47:0] cfg_data = '0;

  pair_mark_correlation_table_core #(.TABLE_ENTRIES(SLOTS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor configuration and table copy.
  logic [47:0] win_t, cool_t, stale_t;
  logic [31:0] tctx_m, mem_m, dup_m;
  logic        tbl_valid  [SLOTS];
  logic [31:0] tbl_act    [SLOTS];
  logic [31:0] tbl_tgt    [SLOTS];
  logic [5:0]  tbl_marks  [SLOTS];
  logic [31:0] tbl_flags  [SLOTS];
  logic [31:0] tbl_access [SLOTS];
  logic [31:0] tbl_age    [SLOTS];
  logic [62:0] tbl_first  [SLOTS];
  logic [62:0] tbl_seen   [SLOTS];
  logic [62:0] tbl_strong [SLOTS];

  event_t  pending_events[$];
  detect_t expected_detections[$];
  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;

  function automatic logic [62:0] elapsed(logic [62:0] now, logic [62:0] then);
    return (now > then) ? now - then : 63'd0;
  endfunction

  function automatic void push_detect(logic [2:0] code, logic [2:0] sev,
      logic [31:0] a, logic [31:0] t, logic [31:0] f, logic [31:0] acc,
      logic [31:0] ag);
    detect_t d;
    d.code = code; d.sev = sev; d.act = a; d.tgt = t;
    d.flags = f; d.access = acc; d.age = ag; d.last = 1'b0;
    expected_detections.push_back(d);
  endfunction

  // Scan order: free slot, matching pair, first stale, else oldest.
  function automatic int pick_slot(logic [31:0] a, logic [31:0] t, logic [62:0] now);
    logic [62:0] oldest;
    int cand;
    oldest = TMAX;
    cand = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_valid[i]) begin
        cand = i;
        break;
      end
      if (tbl_act[i] == a && tbl_tgt[i] == t) return i;
      if ({1'b0, elapsed(now, tbl_seen[i])} > {16'd0, stale_t}) begin
        cand = i;
        break;
      end
      if (tbl_seen[i] < oldest) begin
        oldest = tbl_seen[i];
        cand = i;
      end
    end
    if (cand >= 0) begin
      tbl_valid[cand] = 1'b1; tbl_act[cand] = a; tbl_tgt[cand] = t;
      tbl_marks[cand] = '0; tbl_flags[cand] = '0; tbl_access[cand] = '0;
      tbl_age[cand] = '0; tbl_first[cand] = now; tbl_seen[cand] = now;
      tbl_strong[cand] = '0;
    end
    return cand;
  endfunction

  // Work out the detections one accepted event causes.
  function automatic void predict_detections(event_t e);
    logic [31:0] a;
    logic remote, rnx, tctx, mem, dup, strong_chain;
    logic [5:0] marks, m;
    int n0, s;
    if (e.tgt == 0) return;
    n0 = expected_detections.size();
    a = (e.act == 0) ? e.tgt : e.act;
    remote = (a != e.tgt);
    rnx = remote && e.got && e.exe && e.nonimg;
    tctx = (e.flags & tctx_m) != 0;
    mem = (e.flags & mem_m) != 0;
    dup = (e.flags & dup_m) != 0;
    if (remote && mem && (tctx || dup))
      push_detect(pmct_pkg::DET_INTENT, 3'd5, a, e.tgt, e.flags, e.access, e.age);
    if (rnx && mem)
      push_detect(pmct_pkg::DET_NONIMG, 3'd6, a, e.tgt, e.flags, e.access, e.age);
    if (rnx && tctx && mem)
      push_detect(pmct_pkg::DET_HIJACK, 3'd6, a, e.tgt, e.flags, e.access, e.age);
    if (rnx && mem && (tctx || dup))
      push_detect(pmct_pkg::DET_CHAIN, 3'd7, a, e.tgt, e.flags, e.access, e.age);
    if (rnx && mem && tctx)
      push_detect(pmct_pkg::DET_MMAP, 3'd6, a, e.tgt, e.flags, e.access, e.age);
    marks = (remote ? MK_REMOTE : 6'h0) | (e.outside ? MK_OUTSIDE : 6'h0) |
            (rnx ? MK_NONIMG : 6'h0) | (mem ? MK_MEM : 6'h0) |
            (tctx ? MK_TCTX : 6'h0) | (dup ? MK_DUP : 6'h0);
    if (marks != 0) begin
      s = pick_slot(a, e.tgt, e.now);
      if (s >= 0) begin
        tbl_marks[s] |= marks;
        tbl_flags[s] |= e.flags;
        tbl_access[s] |= e.access;
        if (e.age != 0) tbl_age[s] = e.age;
        tbl_seen[s] = e.now;
        if (tbl_first[s] == 0) tbl_first[s] = e.now;
        if ({1'b0, elapsed(e.now, tbl_first[s])} > {16'd0, win_t}) begin
          tbl_marks[s] = '0; tbl_flags[s] = '0; tbl_access[s] = '0;
          tbl_age[s] = '0; tbl_first[s] = e.now;
        end else begin
          m = tbl_marks[s];
          strong_chain = (m & MK_REMOTE) != 0 && (m & MK_NONIMG) != 0 &&
                         (m & MK_MEM) != 0 && (m & (MK_TCTX | MK_DUP)) != 0;
          if (strong_chain && (tbl_strong[s] == 0 ||
              {1'b0, elapsed(e.now, tbl_strong[s])} >= {16'd0, cool_t})) begin
            tbl_strong[s] = e.now;
            push_detect(pmct_pkg::DET_STRONG, 3'd7, tbl_act[s], tbl_tgt[s],
                        tbl_flags[s], tbl_access[s], tbl_age[s]);
          end
        end
      end
    end
    if (expected_detections.size() > n0)
      expected_detections[expected_detections.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [pmct_pkg::IN_W-1:0] pack_event(event_t e);
    logic [pmct_pkg::IN_W-1:0] v;
    v = '0;
    v[31:0] = e.tgt; v[63:32] = e.act;
    v[64] = e.outside; v[65] = e.got; v[66] = e.exe; v[67] = e.nonimg;
    v[99:68] = e.flags; v[131:100] = e.access; v[163:132] = e.age;
    v[226:164] = e.now;
    return v;
  endfunction

  // Mostly short gaps, a few long, none during calm stretches.
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Sender: present queued requests, predict on acceptance.
  event_t on_bus;
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_detections(on_bus);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          on_bus = pending_events.pop_front();
          in_tdata <= pack_event(on_bus);
          in_tvalid <= 1'b1;
          send_gap = gap_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls on the result side.
  int stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall = gap_len();
    end
  end

  // Check each accepted detection against the oldest expectation.
  always @(posedge clk) begin
    detect_t x;
    logic [31:0] got_age;
    if (rst_n && out_tvalid && out_tready) begin
      got_age = out_tdata[165:134];
      if (expected_detections.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected detection: tdata=%h last=%b", out_tdata, out_tlast);
      end else begin
        x = expected_detections.pop_front();
        if (out_tdata[2:0] !== x.code || out_tdata[5:3] !== x.sev ||
            out_tdata[37:6] !== x.act || out_tdata[69:38] !== x.tgt ||
            out_tdata[101:70] !== x.flags || out_tdata[133:102] !== x.access ||
            got_age !== x.age || out_tlast !== x.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp code=%0d sev=%0d act=%h tgt=%h flg=%h acc=%h age=%h last=%b",
                     x.code, x.sev, x.act, x.tgt, x.flags, x.access, x.age, x.last);
            $display("          got code=%0d sev=%0d act=%h tgt=%h flg=%h acc=%h age=%h last=%b",
                     out_tdata[2:0], out_tdata[5:3], out_tdata[37:6], out_tdata[69:38],
                     out_tdata[101:70], out_tdata[133:102], got_age, out_tlast);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_events.size() > 0 || in_tvalid || expected_detections.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drive one register write; the caller lowers the enable afterwards.
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      pmct_pkg::CFG_WINDOW:   win_t = val;
      pmct_pkg::CFG_COOLDOWN: cool_t = val;
      pmct_pkg::CFG_STALE:    stale_t = val;
      pmct_pkg::CFG_TCTX:     tctx_m = val[31:0];
      pmct_pkg::CFG_MEM:      mem_m = val[31:0];
      pmct_pkg::CFG_DUP:      dup_m = val[31:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [47:0] w, logic [47:0] c, logic [47:0] st,
                             logic [31:0] tm, logic [31:0] mm, logic [31:0] dm);
    write_reg(pmct_pkg::CFG_WINDOW, w);
    write_reg(pmct_pkg::CFG_COOLDOWN, c);
    write_reg(pmct_pkg::CFG_STALE, st);
    write_reg(pmct_pkg::CFG_TCTX, {16'd0, tm});
    write_reg(pmct_pkg::CFG_MEM, {16'd0, mm});
    write_reg(pmct_pkg::CFG_DUP, {16'd0, dm});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic event_t make_event(logic [31:0] t, logic [31:0] a,
      logic [3:0] start_bits, logic [31:0] f, logic [31:0] acc,
      logic [31:0] ag, logic [62:0] now);
    event_t e;
    e.tgt = t; e.act = a;
    {e.nonimg, e.exe, e.got, e.outside} = start_bits;
    e.flags = f; e.access = acc; e.age = ag; e.now = now;
    return e;
  endfunction

  // Random event: chains with random content, plus noise.
  function automatic event_t rand_event(logic [31:0] t, logic [31:0] a, logic [62:0] now);
    event_t e;
    int r;
    e = make_event(t, a, 4'($urandom_range(0, 15)), $urandom, $urandom, $urandom, now);
    r = $urandom_range(0, 9);
    if (r < 6) begin
      e.got = 1'b1; e.exe = 1'b1; e.nonimg = 1'b1;
      e.flags = mem_m | (($urandom_range(0, 1) != 0) ? tctx_m : dup_m) |
                ($urandom & $urandom);
    end else if (r < 8) begin
      e.flags = ($urandom_range(0, 1) != 0) ? mem_m : (tctx_m | dup_m);
    end
    if ($urandom_range(0, 7) == 0) e.age = '0;
    return e;
  endfunction

  initial begin
    logic [62:0] t;
    logic [31:0] pa [8];
    logic [31:0] pt [8];
    int k;
    win_t = 48'd300000000; cool_t = 48'd30000000; stale_t = 48'd600000000;
    tctx_m = 32'd1; mem_m = 32'd2; dup_m = 32'd4;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 0; tbl_act[i] = 0; tbl_tgt[i] = 0; tbl_marks[i] = 0;
      tbl_flags[i] = 0; tbl_access[i] = 0; tbl_age[i] = 0; tbl_first[i] = 0;
      tbl_seen[i] = 0; tbl_strong[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed events under reset configuration.
    t = 63'd1000;
    pending_events.push_back(make_event(32'd0, 32'd5, 4'hF, 32'h7, 32'h1, 32'h1, t));
    pending_events.push_back(make_event(32'd10, 32'd0, 4'h0, 32'h0, 32'h0, 32'h0, t));
    pending_events.push_back(make_event(32'd10, 32'd10, 4'h1, 32'h0, 32'h0, 32'h0, t));
    pending_events.push_back(make_event(32'd10, 32'd0, 4'h0, 32'h7, 32'hFFFF_FFFF, 32'h0, t));
    // full chain: every immediate detection plus strong
    pending_events.push_back(make_event(32'd20, 32'd21, 4'hE, 32'h3, 32'hA5A5_0001,
                                        32'd30000, t + 1));
    // inside cooldown: no strong; zero age keeps stored
    pending_events.push_back(make_event(32'd20, 32'd21, 4'hE, 32'h6, 32'h0000_0100,
                                        32'd0, t + 2));
    // past cooldown
    pending_events.push_back(make_event(32'd20, 32'd21, 4'hE, 32'h3, 32'h1, 32'd3000,
                                        t + 30000010));
    // window expired
    pending_events.push_back(make_event(32'd20, 32'd21, 4'hE, 32'h3, 32'h2, 32'd7,
                                        t + 300001500));
    // time going backwards
    pending_events.push_back(make_event(32'd20, 32'd21, 4'hE, 32'h3, 32'h4, 32'd9, 63'd5));
    // remote without non-image start, dup only intent
    pending_events.push_back(make_event(32'd30, 32'd31, 4'h6, 32'h6, 32'h8, 32'd1, t));
    pending_events.push_back(make_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TMAX));
    pending_events.push_back(make_event(32'hFFFF_FFFF, 32'h1, 4'hE,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TMAX));
    pending_events.push_back(make_event(32'h1, 32'hFFFF_FFFF, 4'hE, 32'h3, 32'h0, 32'h0, 63'd0));
    pending_events.push_back(make_event(32'h1, 32'hFFFF_FFFF, 4'hE, 32'h5, 32'h0, 32'h0, 63'd0));
    // hold the sender until all results are back
    wait_idle();

    // Wide window, no cooldown, maximum stale: mostly a small pair pool, rising time.
    load_config(48'hFFFF_FFFF_FFFF, 48'd0, 48'hFFFF_FFFF_FFFF, 32'd1, 32'd2, 32'd4);
    for (int i = 0; i < 8; i++) begin
      pt[i] = $urandom_range(1, 40);
      pa[i] = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(41, 80);
    end
    for (int i = 0; i < 20; i++) begin
      calm = (i >= 8 && i < 14);
      t = t + $urandom_range(0, 100000);
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 9) == 0)
        pending_events.push_back(rand_event($urandom, $urandom, 63'({$urandom, $urandom})));
      else
        pending_events.push_back(rand_event(pt[k], pa[k], t));
    end
    wait_idle();

    // Short window and cooldown, moderate stale: mostly fresh pairs.
    load_config(48'd1000, 48'd500, 48'd2000, 32'h8000_0000, 32'h0000_0F00, 32'hFFFF_FFFF);
    t = 63'd10;
    for (int i = 0; i < 20; i++) begin
      calm = (i >= 12);
      t = t + $urandom_range(0, 700);
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 2) == 0)
        pending_events.push_back(rand_event(pt[k], pa[k], t));
      else
        pending_events.push_back(rand_event($urandom | 32'd1, $urandom, t));
    end
    wait_idle();

    // Zero window and stale, maximum cooldown, all at maximum time: fills the
    // table with fresh pairs until every slot is pinned and the rest are dropped.
    load_config(48'd0, 48'hFFFF_FFFF_FFFF, 48'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
    calm = 1'b0;
    for (int i = 0; i < 262; i++) begin
      pending_events.push_back(rand_event($urandom | 32'd1, $urandom, TMAX));
    end
    wait_idle();

    if (mismatches == 0 && expected_detections.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/pmct_pkg.sv
design/pmct_ctrl.sv
design/pmct_dp.sv
design/pair_mark_correlation_table_core.sv
verif/pair_mark_correlation_table_core_test.sv
